// File: hdl/dlbg_pkg.sv
package dlbg_pkg;

    localparam int LABEL_W = 12;
    localparam int CNT_W   = 19;

    localparam int NUM_LABELS_DEF = 4096;
    localparam int MAX_PIXELS     = 262144;

    // A count stops at the frame size or at the field maximum, whichever is lower.
    localparam int CNT_FIELD_MAX = (1 << CNT_W) - 1;
    localparam logic [CNT_W-1:0] CNT_CAP =
        CNT_W'((MAX_PIXELS < CNT_FIELD_MAX) ? MAX_PIXELS : CNT_FIELD_MAX);

    localparam logic OP_COUNT   = 1'b0;
    localparam logic OP_RELABEL = 1'b1;

    localparam logic KIND_PIXEL  = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef struct packed {
        logic               op;
        logic [LABEL_W-1:0] pixel_label;
        logic               frame_end;
    } t_in_item;

    typedef struct packed {
        logic               kind;
        logic [LABEL_W-1:0] value_label;
        logic [CNT_W-1:0]   dominant_count;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DRAIN,
        ST_SCAN,
        ST_TAIL,
        ST_REPORT
    } t_state;

endpackage

// File: hdl/dlbg_ram.sv
module dlbg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read returns the old contents when the same entry is written at the same edge.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/dominant_label_to_background.sv
// Channel | Direction | Handshake                 | Payload
// in      | input     | i_in_valid / o_in_ready   | i_in  (dlbg_pkg::t_in_item)
// out     | output    | o_out_valid / i_out_ready | o_out (dlbg_pkg::t_out_item)
//
// Counting and relabel pixels are taken one per cycle while the block is idle; the
// histogram is a single RAM with registered read, updated read-modify-write with a bypass.
// A frame end pixel then drains the pipeline, and the RAM port walks every entry
// once, finding the argmax and writing the entry back to zero.
// After reset a clearing pass writes every entry to zero before the first request.
// Input is held off while the output register is full and not being taken.
module dominant_label_to_background #(
    parameter int NUM_LABELS = dlbg_pkg::NUM_LABELS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  dlbg_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output dlbg_pkg::t_out_item o_out
);

    localparam int AW = $clog2(NUM_LABELS);
    localparam logic [AW-1:0] LAST_IDX = AW'(NUM_LABELS - 1);
    localparam int CW = dlbg_pkg::CNT_W;
    localparam int LW = dlbg_pkg::LABEL_W;

    dlbg_pkg::t_state    r_state, n_state;
    logic [AW-1:0]       r_idx, n_idx;
    logic                r_sv, n_sv;
    logic [AW-1:0]       r_sidx, n_sidx;
    logic                r_s1_v, n_s1_v;
    logic [AW-1:0]       r_s1_addr, n_s1_addr;
    logic                r_byp, n_byp;
    logic [CW-1:0]       r_byp_cnt, n_byp_cnt;
    logic [AW-1:0]       r_best_lbl, n_best_lbl;
    logic [CW-1:0]       r_best_cnt, n_best_cnt;
    logic [LW-1:0]       r_bg, n_bg;
    logic                r_out_valid, n_out_valid;
    dlbg_pkg::t_out_item r_out, n_out;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [CW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [CW-1:0] ram_rdata;

    logic          in_ready;
    logic          in_acc;
    logic          in_range;
    logic [AW-1:0] in_addr;
    logic          cnt_acc;
    logic [CW-1:0] s1_cur;
    logic [CW-1:0] s1_new;
    logic [LW-1:0] relabel;

    dlbg_ram #(
        .WIDTH(CW),
        .DEPTH(NUM_LABELS)
    ) u_hist (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign in_ready = (r_state == dlbg_pkg::ST_IDLE) && (!r_out_valid || i_out_ready);
    assign in_acc   = i_in_valid && in_ready;
    assign in_range = 32'(i_in.pixel_label) < NUM_LABELS;
    assign in_addr  = AW'(i_in.pixel_label);
    assign cnt_acc  = in_acc && (i_in.op == dlbg_pkg::OP_COUNT) && in_range;

    // A repeat label read this entry at the edge that writes it, so the bypass gives the new count.
    assign s1_cur = r_byp ? r_byp_cnt : ram_rdata;
    assign s1_new = (s1_cur < dlbg_pkg::CNT_CAP) ? s1_cur + CW'(1) : s1_cur;

    assign ram_raddr = (r_state == dlbg_pkg::ST_SCAN) ? r_idx : in_addr;

    always_comb begin
        relabel = i_in.pixel_label;
        if (r_bg != '0) begin
            if (i_in.pixel_label == '0) begin
                relabel = r_bg;
            end else if (i_in.pixel_label == r_bg) begin
                relabel = '0;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_sv        = 1'b0;
        n_sidx      = r_sidx;
        n_s1_v      = cnt_acc;
        n_s1_addr   = in_addr;
        n_byp       = cnt_acc && r_s1_v && (r_s1_addr == in_addr);
        n_byp_cnt   = s1_new;
        n_best_lbl  = r_best_lbl;
        n_best_cnt  = r_best_cnt;
        n_bg        = r_bg;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        ram_we    = 1'b0;
        ram_waddr = r_s1_addr;
        ram_wdata = s1_new;

        if (r_state == dlbg_pkg::ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_idx;
            ram_wdata = '0;
        end else if (r_sv) begin
            ram_we    = 1'b1;
            ram_waddr = r_sidx;
            ram_wdata = '0;
        end else if (r_s1_v) begin
            ram_we = 1'b1;
        end

        // Strictly greater keeps the smallest label on a tie.
        if (r_sv && (ram_rdata > r_best_cnt)) begin
            n_best_lbl = r_sidx;
            n_best_cnt = ram_rdata;
        end

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            dlbg_pkg::ST_CLEAR: begin
                n_idx = r_idx + 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_idx   = '0;
                    n_state = dlbg_pkg::ST_IDLE;
                end
            end
            dlbg_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (i_in.op == dlbg_pkg::OP_RELABEL) begin
                        n_out_valid          = 1'b1;
                        n_out.kind           = dlbg_pkg::KIND_PIXEL;
                        n_out.value_label    = relabel;
                        n_out.dominant_count = '0;
                    end else if (i_in.frame_end) begin
                        n_state = dlbg_pkg::ST_DRAIN;
                    end
                end
            end
            dlbg_pkg::ST_DRAIN: begin
                n_idx      = '0;
                n_best_lbl = '0;
                n_best_cnt = '0;
                n_state    = dlbg_pkg::ST_SCAN;
            end
            dlbg_pkg::ST_SCAN: begin
                n_sv   = 1'b1;
                n_sidx = r_idx;
                n_idx  = r_idx + 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_idx   = '0;
                    n_state = dlbg_pkg::ST_TAIL;
                end
            end
            dlbg_pkg::ST_TAIL: begin
                n_state = dlbg_pkg::ST_REPORT;
            end
            dlbg_pkg::ST_REPORT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid          = 1'b1;
                    n_out.kind           = dlbg_pkg::KIND_REPORT;
                    n_out.value_label    = LW'(r_best_lbl);
                    n_out.dominant_count = r_best_cnt;
                    n_bg                 = LW'(r_best_lbl);
                    n_state              = dlbg_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dlbg_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dlbg_pkg::ST_CLEAR;
            r_idx       <= '0;
            r_sv        <= 1'b0;
            r_s1_v      <= 1'b0;
            r_byp       <= 1'b0;
            r_bg        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_sv        <= n_sv;
            r_s1_v      <= n_s1_v;
            r_byp       <= n_byp;
            r_bg        <= n_bg;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sidx     <= n_sidx;
        r_s1_addr  <= n_s1_addr;
        r_byp_cnt  <= n_byp_cnt;
        r_best_lbl <= n_best_lbl;
        r_best_cnt <= n_best_cnt;
        r_out      <= n_out;
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// File: hdl/dlbg_checker.sv
module dlbg_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input dlbg_pkg::t_out_item o_out
);

    // The output register holds its request until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("output request dropped or changed while stalled");

    // Pixel results never carry a count.
    a_pixel_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.kind == dlbg_pkg::KIND_PIXEL) |-> o_out.dominant_count == '0)
        else $error("pixel result with nonzero count");

    // A reported count never passes the saturation limit.
    a_report_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.kind == dlbg_pkg::KIND_REPORT)
            |-> o_out.dominant_count <= dlbg_pkg::CNT_CAP)
        else $error("reported count above saturation limit");

    // The histogram clearing pass keeps the input closed right after reset.
    a_reset_clear: assert property (@(posedge i_clk)
        $past(!i_rst_n) && i_rst_n |-> !o_in_ready)
        else $error("input ready before histogram was cleared");

endmodule

bind dominant_label_to_background dlbg_checker u_dlbg_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_in_ready (o_in_ready),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out      (o_out)
);

// File: sim/dominant_label_to_background_tb.sv
`timescale 1ns / 100ps

module dominant_label_to_background_tb;

    localparam int NUM_LABELS    = dlbg_pkg::NUM_LABELS_DEF;
    localparam int LONG_HOLD     = 300;
    localparam int RANDOM_PIXELS = 1300;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    dlbg_pkg::t_in_item  i_in;
    logic                o_out_valid;
    logic                i_out_ready;
    dlbg_pkg::t_out_item o_out;

    bit hold_wanted;
    int burst_left;
    int random_sent;

    // Mirrors the histogram and the background label, and holds the results
    // that the block owes in the order they were requested.
    class dominant_label_board;
        logic [dlbg_pkg::CNT_W-1:0]   histogram [NUM_LABELS];
        logic [dlbg_pkg::LABEL_W-1:0] background;
        dlbg_pkg::t_out_item          expected_q [$];
        int                           mismatches;
        int                           requests;
        int                           pixels_seen;
        int                           reports_seen;
        int                           top_count;

        function new();
            foreach (histogram[i]) histogram[i] = '0;
            background   = '0;
            mismatches   = 0;
            requests     = 0;
            pixels_seen  = 0;
            reports_seen = 0;
            top_count    = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report_mismatch(input string what);
            if (mismatches < 30) $display("%0t ns: mismatch: %s", $time, what);
            mismatches++;
        endtask

        function void note_request(input dlbg_pkg::t_in_item req);
            dlbg_pkg::t_out_item          res;
            logic [dlbg_pkg::LABEL_W-1:0] best;
            logic [dlbg_pkg::CNT_W-1:0]   best_cnt;
            requests++;
            if (req.op == dlbg_pkg::OP_RELABEL) begin
                res.kind           = dlbg_pkg::KIND_PIXEL;
                res.dominant_count = '0;
                res.value_label    = req.pixel_label;
                if (background != '0) begin
                    if (req.pixel_label == '0) res.value_label = background;
                    else if (req.pixel_label == background) res.value_label = '0;
                end
                expected_q = {expected_q, res};
                return;
            end
            if (req.pixel_label < NUM_LABELS && histogram[req.pixel_label] < dlbg_pkg::CNT_CAP)
                histogram[req.pixel_label]++;
            if (!req.frame_end) return;
            // Strictly greater keeps the smallest label on a tie.
            best     = '0;
            best_cnt = histogram[0];
            for (int i = 1; i < NUM_LABELS; i++) begin
                if (histogram[i] > best_cnt) begin
                    best     = dlbg_pkg::LABEL_W'(i);
                    best_cnt = histogram[i];
                end
            end
            background = best;
            foreach (histogram[i]) histogram[i] = '0;
            res.kind           = dlbg_pkg::KIND_REPORT;
            res.value_label    = best;
            res.dominant_count = best_cnt;
            expected_q = {expected_q, res};
        endfunction

        task check_result(input dlbg_pkg::t_out_item got);
            dlbg_pkg::t_out_item want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unrequested result kind=%0b label=%0d count=%0d",
                                          got.kind, got.value_label, got.dominant_count));
                return;
            end
            want = expected_q.pop_front();
            if (got.kind !== want.kind)
                report_mismatch($sformatf("kind %0b, wanted %0b", got.kind, want.kind));
            if (got.value_label !== want.value_label)
                report_mismatch($sformatf("value_label %0d, wanted %0d (kind %0b)",
                                          got.value_label, want.value_label, want.kind));
            if (got.dominant_count !== want.dominant_count)
                report_mismatch($sformatf("dominant_count %0d, wanted %0d (kind %0b)",
                                          got.dominant_count, want.dominant_count, want.kind));
            if (want.kind == dlbg_pkg::KIND_REPORT) begin
                reports_seen++;
                if (int'(want.dominant_count) > top_count) top_count = want.dominant_count;
            end else begin
                pixels_seen++;
            end
        endtask
    endclass

    dominant_label_board board;

    dominant_label_to_background #(
        .NUM_LABELS (NUM_LABELS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Both handshakes are seen in one process, so a request is always noted
    // before any result it causes is checked.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) board.note_request(i_in);
            if (o_out_valid && i_out_ready) board.check_result(o_out);
        end
    end

    // Receiver: switches among stall patterns, and on request holds off for a
    // long stretch so that the block backs up into its input.
    initial begin
        int mode;
        int span;
        i_out_ready = 1'b0;
        mode        = 0;
        span        = 0;
        forever begin
            @(negedge i_clk);
            if (hold_wanted) begin
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
                hold_wanted = 1'b0;
            end else begin
                if (span == 0) begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(10, 60);
                end
                span--;
                case (mode)
                    0: begin
                        i_out_ready <= 1'b1;
                    end
                    1: begin
                        i_out_ready <= 1'($urandom_range(0, 1));
                    end
                    2: begin
                        i_out_ready <= ($urandom_range(0, 3) == 0);
                    end
                    default: begin
                        i_out_ready <= ($urandom_range(0, 3) != 0);
                    end
                endcase
            end
        end
    end

    initial begin
        #200_000_000;
        $display("Run timed out with %0d results outstanding.", board.pending());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic offer(input logic op, input logic [dlbg_pkg::LABEL_W-1:0] label,
                         input logic fend);
        dlbg_pkg::t_in_item req;
        req.op          = op;
        req.pixel_label = label;
        req.frame_end   = fend;
        i_in_valid <= 1'b1;
        i_in       <= req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic idle_cycles(input int n);
        i_in_valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // Sender pacing: bursts of random length, some long, split by random gaps.
    task automatic send_paced(input logic op, input logic [dlbg_pkg::LABEL_W-1:0] label,
                              input logic fend);
        offer(op, label, fend);
        random_sent++;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            idle_cycles($urandom_range(1, 8));
        end else begin
            burst_left--;
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        int                           frame_len;
        int                           pass_len;
        logic [dlbg_pkg::LABEL_W-1:0] palette [4];
        logic [dlbg_pkg::LABEL_W-1:0] lbl;
        board       = new();
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in        = '0;
        hold_wanted = 1'b0;
        burst_left  = 0;
        random_sent = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Before any report the background is 0; the end flag is ignored
        // when relabeling.
        offer(dlbg_pkg::OP_RELABEL, 12'd0, 1'b0);
        offer(dlbg_pkg::OP_RELABEL, 12'd4095, 1'b1);
        // Tie between 4095 and 7 goes to the smaller label.
        offer(dlbg_pkg::OP_COUNT, 12'd4095, 1'b0);
        offer(dlbg_pkg::OP_COUNT, 12'd4095, 1'b0);
        offer(dlbg_pkg::OP_COUNT, 12'd7, 1'b0);
        offer(dlbg_pkg::OP_COUNT, 12'd7, 1'b1);
        offer(dlbg_pkg::OP_RELABEL, 12'd0, 1'b0);
        offer(dlbg_pkg::OP_RELABEL, 12'd7, 1'b0);
        offer(dlbg_pkg::OP_RELABEL, 12'd4095, 1'b0);
        offer(dlbg_pkg::OP_RELABEL, 12'd7, 1'b1);
        // The histogram must have been cleared by the previous report.
        offer(dlbg_pkg::OP_COUNT, 12'd4095, 1'b1);
        offer(dlbg_pkg::OP_RELABEL, 12'd0, 1'b0);
        offer(dlbg_pkg::OP_RELABEL, 12'd4095, 1'b0);
        offer(dlbg_pkg::OP_RELABEL, 12'd1, 1'b0);
        // A dominant label of 0 makes relabeling a pass-through again.
        offer(dlbg_pkg::OP_COUNT, 12'd0, 1'b1);
        offer(dlbg_pkg::OP_RELABEL, 12'd0, 1'b0);
        offer(dlbg_pkg::OP_RELABEL, 12'd5, 1'b0);
        offer(dlbg_pkg::OP_COUNT, 12'd2, 1'b0);
        offer(dlbg_pkg::OP_COUNT, 12'd1, 1'b0);
        offer(dlbg_pkg::OP_COUNT, 12'd1, 1'b1);
        wait_drained();

        // Long receiver hold-off with the sender pushing back to back.
        hold_wanted = 1'b1;
        for (int i = 0; i < 40; i++) begin
            lbl = ($urandom_range(0, 2) == 0) ? 12'd0
                                              : dlbg_pkg::LABEL_W'($urandom_range(0, 3));
            offer(dlbg_pkg::OP_RELABEL, lbl, 1'($urandom_range(0, 1)));
        end
        wait_drained();

        while (random_sent < RANDOM_PIXELS) begin
            if ($urandom_range(0, 9) < 8) begin
                // A counting frame drawn from a small palette, then a relabel pass.
                palette[0] = dlbg_pkg::LABEL_W'($urandom_range(0, 4095));
                palette[1] = '0;
                palette[2] = dlbg_pkg::LABEL_W'($urandom_range(0, 4095));
                palette[3] = ($urandom_range(0, 1) == 0)
                           ? 12'd4095 : dlbg_pkg::LABEL_W'($urandom_range(0, 4095));
                frame_len = $urandom_range(1, 30);
                for (int i = 0; i < frame_len; i++) begin
                    lbl = ($urandom_range(0, 9) < 4) ? palette[0]
                                                     : palette[$urandom_range(0, 3)];
                    send_paced(dlbg_pkg::OP_COUNT, lbl, i == frame_len - 1);
                end
                pass_len = $urandom_range(1, 30);
                for (int i = 0; i < pass_len; i++) begin
                    lbl = ($urandom_range(0, 4) == 0)
                        ? dlbg_pkg::LABEL_W'($urandom_range(0, 4095))
                        : palette[$urandom_range(0, 3)];
                    send_paced(dlbg_pkg::OP_RELABEL, lbl, 1'($urandom_range(0, 1)));
                end
            end else begin
                for (int i = 0; i < 10; i++)
                    send_paced(1'($urandom_range(0, 1)),
                               dlbg_pkg::LABEL_W'($urandom_range(0, 4095)),
                               $urandom_range(0, 15) == 0);
            end
        end
        wait_drained();

        repeat (NUM_LABELS + 50) @(posedge i_clk);
        $display("Checked %0d requests: %0d relabeled pixels and %0d frame reports,",
                 board.requests, board.pixels_seen, board.reports_seen);
        $display("with the largest dominant count reported being %0d.", board.top_count);
        if (board.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
